// File: rtl/core/rkor_pkg.sv
// shared types, action codes and ring interval helper for the key ownership router
package rkor_pkg;

    localparam int unsigned CfgAddrWidth = 5;
    localparam int unsigned CfgDataWidth = 32;

    typedef enum logic [2:0] {
        REG_SELF_NODE_ID  = 3'd0,
        REG_PRED_NODE_ID  = 3'd1,
        REG_SUCC_NODE_ID  = 3'd2,
        REG_SELF_IPV4     = 3'd3,
        REG_SELF_UDP_PORT = 3'd4,
        REG_SUCC_IPV4     = 3'd5,
        REG_SUCC_UDP_PORT = 3'd6,
        REG_NONE          = 3'd7
    } t_reg_index;

    typedef enum logic [3:0] {
        ACT_SERVE       = 4'd0,
        ACT_REDIR_SUCC  = 4'd1,
        ACT_REDIR_CACHE = 4'd2,
        ACT_BUSY_CACHE  = 4'd3,
        ACT_BUSY_LOOKUP = 4'd4,
        ACT_REPLY_SELF  = 4'd5,
        ACT_REPLY_SUCC  = 4'd6,
        ACT_FORWARD     = 4'd7,
        ACT_STORED      = 4'd8,
        ACT_IGNORED     = 4'd9
    } t_action;

    localparam logic [7:0] MSG_LOOKUP = 8'd0;
    localparam logic [7:0] MSG_REPLY  = 8'd1;

    localparam logic OUT_KIND_LOOKUP = 1'b0;
    localparam logic OUT_KIND_REPLY  = 1'b1;

    localparam logic MODE_CLIENT   = 1'b0;
    localparam logic MODE_DATAGRAM = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] key_hash;
        logic [7:0]  msg_kind;
        logic [15:0] msg_node_id;
        logic [31:0] msg_node_ip;
        logic [15:0] msg_node_port;
    } t_in_word;

    typedef struct packed {
        t_action     action;
        logic        out_kind;
        logic [15:0] out_key;
        logic [15:0] out_node_id;
        logic [31:0] out_node_ip;
        logic [15:0] out_node_port;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
    } t_out_word;

    typedef struct packed {
        logic [15:0] self_node_id;
        logic [15:0] pred_node_id;
        logic [15:0] succ_node_id;
        logic [31:0] self_ipv4;
        logic [15:0] self_udp_port;
        logic [31:0] succ_ipv4;
        logic [15:0] succ_udp_port;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [31:0] peer_ip;
        logic [15:0] peer_udp;
    } t_cache;

    // key in the ring interval (lo, hi]
    function automatic logic rkor_owns(input logic [15:0] key, input logic [15:0] hi,
                                       input logic [15:0] lo);
        if (lo < hi) begin
            return (key > lo) && (key <= hi);
        end
        return (key > lo) || (key <= hi);
    endfunction

endpackage

// File: rtl/core/rkor_decide.sv
// ownership decision and outgoing word build for one event, with next cache state
module rkor_decide (
    input  rkor_pkg::t_in_word  i_word,
    input  rkor_pkg::t_cfg      i_cfg,
    input  rkor_pkg::t_cache    i_cache,
    output rkor_pkg::t_out_word o_result,
    output rkor_pkg::t_cache    o_cache
);
    import rkor_pkg::*;

    logic lone_ring;
    logic self_owns;
    logic succ_owns;

    assign lone_ring = ((i_cfg.pred_node_id == i_cfg.self_node_id) &&
                        (i_cfg.succ_node_id == i_cfg.self_node_id)) ||
                       ((i_cfg.pred_node_id == '0) && (i_cfg.succ_node_id == '0));
    assign self_owns = rkor_owns(i_word.key_hash, i_cfg.self_node_id, i_cfg.pred_node_id);
    assign succ_owns = rkor_owns(i_word.key_hash, i_cfg.succ_node_id, i_cfg.self_node_id);

    always_comb begin
        o_result = '0;
        o_result.action = ACT_IGNORED;
        o_cache = i_cache;
        if (i_word.mode == MODE_CLIENT) begin
            priority if (lone_ring || self_owns) begin
                o_result.action = ACT_SERVE;
            end else if (i_cfg.succ_node_id == i_cfg.pred_node_id) begin
                o_result.action    = ACT_REDIR_SUCC;
                o_result.dest_ip   = i_cfg.succ_ipv4;
                o_result.dest_port = i_cfg.succ_udp_port;
            end else if (i_cache.valid) begin
                o_result.action    = ACT_REDIR_CACHE;
                o_result.dest_ip   = i_cache.peer_ip;
                o_result.dest_port = i_cache.peer_udp;
                o_cache.valid      = 1'b0;
            end else if (succ_owns) begin
                o_result.action   = ACT_BUSY_CACHE;
                o_cache.valid     = 1'b1;
                o_cache.peer_ip   = i_cfg.succ_ipv4;
                o_cache.peer_udp  = i_cfg.succ_udp_port;
            end else begin
                o_result.action        = ACT_BUSY_LOOKUP;
                o_result.out_kind      = OUT_KIND_LOOKUP;
                o_result.out_key       = i_word.key_hash;
                o_result.out_node_id   = i_cfg.self_node_id;
                o_result.out_node_ip   = i_cfg.self_ipv4;
                o_result.out_node_port = i_cfg.self_udp_port;
                o_result.dest_ip       = i_cfg.succ_ipv4;
                o_result.dest_port     = i_cfg.succ_udp_port;
            end
        end else if (i_word.msg_kind == MSG_LOOKUP) begin
            priority if (self_owns) begin
                o_result.action        = ACT_REPLY_SELF;
                o_result.out_kind      = OUT_KIND_REPLY;
                o_result.out_key       = i_cfg.pred_node_id;
                o_result.out_node_id   = i_cfg.self_node_id;
                o_result.out_node_ip   = i_cfg.self_ipv4;
                o_result.out_node_port = i_cfg.self_udp_port;
                o_result.dest_ip       = i_word.msg_node_ip;
                o_result.dest_port     = i_word.msg_node_port;
            end else if (succ_owns) begin
                o_result.action        = ACT_REPLY_SUCC;
                o_result.out_kind      = OUT_KIND_REPLY;
                o_result.out_key       = i_cfg.self_node_id;
                o_result.out_node_id   = i_cfg.succ_node_id;
                o_result.out_node_ip   = i_cfg.succ_ipv4;
                o_result.out_node_port = i_cfg.succ_udp_port;
                o_result.dest_ip       = i_word.msg_node_ip;
                o_result.dest_port     = i_word.msg_node_port;
            end else begin
                o_result.action        = ACT_FORWARD;
                o_result.out_kind      = OUT_KIND_LOOKUP;
                o_result.out_key       = i_word.key_hash;
                o_result.out_node_id   = i_word.msg_node_id;
                o_result.out_node_ip   = i_word.msg_node_ip;
                o_result.out_node_port = i_word.msg_node_port;
                o_result.dest_ip       = i_cfg.succ_ipv4;
                o_result.dest_port     = i_cfg.succ_udp_port;
            end
        end else if (i_word.msg_kind == MSG_REPLY) begin
            o_result.action   = ACT_STORED;
            o_cache.valid     = 1'b1;
            o_cache.peer_ip   = i_word.msg_node_ip;
            o_cache.peer_udp  = i_word.msg_node_port;
        end
    end

endmodule

// File: rtl/core/ring_key_ownership_router.sv
// top level of the ring key ownership router: register port, peer cache, output skid
// Takes one event per word (a client request with a hashed key, or a received ring
// datagram), decides which node on the 16-bit ring owns the key and returns one result
// word with the action code, the outgoing datagram fields and the destination. Each
// event is decided in the cycle it is accepted and a new word can be taken every cycle
// while the skid register is empty. The single-entry peer cache is updated at acceptance,
// so back-to-back events see each other's cache effect in order. A two-deep output stage
// (result register plus skid register) lets the input keep flowing for one word while the
// consumer stalls. Registers sit on an APB-style port at byte addresses
// 0x00 self id, 0x04 predecessor id, 0x08 successor id, 0x0C self IPv4, 0x10 self port,
// 0x14 successor IPv4, 0x18 successor port; write them only while the block is idle.
module ring_key_ownership_router (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rkor_pkg::CfgAddrWidth-1:0]   paddr,
    input  logic [rkor_pkg::CfgDataWidth-1:0]   pwdata,
    output logic [rkor_pkg::CfgDataWidth-1:0]   prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rkor_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rkor_pkg::t_out_word                 o_out_word
);
    import rkor_pkg::*;

    t_cfg       r_cfg;
    t_cache     r_cache;
    t_cache     n_cache;
    t_out_word  n_result;
    t_out_word  r_out_word;
    t_out_word  r_skid_word;
    logic       r_out_valid;
    logic       r_skid_valid;
    logic       in_fire;
    logic       out_fire;
    logic       cfg_write;
    t_reg_index reg_index;

    assign pready     = 1'b1;
    assign reg_index  = t_reg_index'(paddr[4:2]);
    assign cfg_write  = psel && penable && pwrite;
    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_SELF_NODE_ID:  r_cfg.self_node_id  <= pwdata[15:0];
                REG_PRED_NODE_ID:  r_cfg.pred_node_id  <= pwdata[15:0];
                REG_SUCC_NODE_ID:  r_cfg.succ_node_id  <= pwdata[15:0];
                REG_SELF_IPV4:     r_cfg.self_ipv4     <= pwdata;
                REG_SELF_UDP_PORT: r_cfg.self_udp_port <= pwdata[15:0];
                REG_SUCC_IPV4:     r_cfg.succ_ipv4     <= pwdata;
                REG_SUCC_UDP_PORT: r_cfg.succ_udp_port <= pwdata[15:0];
                REG_NONE:          ;
            endcase
        end
    end

    // register read
    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_SELF_NODE_ID:  prdata = {16'd0, r_cfg.self_node_id};
            REG_PRED_NODE_ID:  prdata = {16'd0, r_cfg.pred_node_id};
            REG_SUCC_NODE_ID:  prdata = {16'd0, r_cfg.succ_node_id};
            REG_SELF_IPV4:     prdata = r_cfg.self_ipv4;
            REG_SELF_UDP_PORT: prdata = {16'd0, r_cfg.self_udp_port};
            REG_SUCC_IPV4:     prdata = r_cfg.succ_ipv4;
            REG_SUCC_UDP_PORT: prdata = {16'd0, r_cfg.succ_udp_port};
            REG_NONE:          prdata = '0;
        endcase
    end

    rkor_decide u_decide (
        .i_word   (i_in_word),
        .i_cfg    (r_cfg),
        .i_cache  (r_cache),
        .o_result (n_result),
        .o_cache  (n_cache)
    );

    // peer cache
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache <= '0;
        end else if (in_fire) begin
            r_cache <= n_cache;
        end
    end

    // result register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (in_fire) begin
                r_out_word <= n_result;
            end
        end else if (in_fire) begin
            r_skid_word <= n_result;
        end
    end

`ifndef SYNTH
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without a result word");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_out_valid && !i_out_ready |=> r_skid_valid)
        else $error("word taken during stall not parked in skid");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_word.mode == MODE_DATAGRAM) && (i_in_word.msg_kind == MSG_REPLY)
        |=> r_cache.valid)
        else $error("reply datagram did not load the peer cache");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (n_result.action == ACT_REDIR_CACHE) |=> !r_cache.valid)
        else $error("cached redirect did not consume the cache");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (n_result.action == ACT_REDIR_CACHE) |-> r_cache.valid)
        else $error("cached redirect issued with an empty cache");
`endif

endmodule
